[design/assert_macros.svh]
// Assertion macros shared by the deframer modules.
// Every macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define VLFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VLFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/vlfd_pkg.sv]
// Shared constants, codes and types for the varint length frame deframer.
// Used by vlfd_front, vlfd_queue and the top level; depends on nothing.
package vlfd_pkg;

    // Width of the body length counter.
    localparam int LEN_CNT_BITS = 25;
    // Width of the maximum frame length register.
    localparam int CFG_W = 25;
    localparam logic [CFG_W-1:0] MAX_FRAME_RESET = CFG_W'(16 * 1024 * 1024);

    // Result queue; depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Input operations.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_DISCARD = 1'b1;

    // Decoder phases.
    localparam logic [1:0] PH_LEN = 2'd0;
    localparam logic [1:0] PH_ID  = 2'd1;
    localparam logic [1:0] PH_PAY = 2'd2;
    localparam logic [1:0] PH_ERR = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NEG      = 2'd0;
    localparam logic [1:0] ERR_OVERLONG = 2'd1;
    localparam logic [1:0] ERR_TOOLONG  = 2'd2;
    localparam logic [1:0] ERR_BADID    = 2'd3;

    // Varints carry at most this many bytes.
    localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         payload_byte;
        logic signed [31:0] frame_tag;
        logic               last_of_frame;
        logic [1:0]         error_code;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage

[design/vlfd_front.sv]
// Front part of the deframer: per-beat varint and length decoding.
// Depends on vlfd_pkg and assert_macros.svh; pushes results to vlfd_queue.
`include "assert_macros.svh"

module vlfd_front
    import vlfd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_accept,
    input  logic             i_op,
    input  logic [7:0]       i_data_byte,
    output t_push            o_push
);

    logic [CFG_W-1:0]        r_max_len,  n_max_len;
    logic [1:0]              r_phase,    n_phase;
    logic [31:0]             r_accum,    n_accum;
    logic [2:0]              r_vcount,   n_vcount;
    logic [LEN_CNT_BITS-1:0] r_rem,      n_rem;
    logic [2:0]              r_hdr_cnt,  n_hdr_cnt;
    logic [31:0]             r_cur_id,   n_cur_id;
    logic [1:0]              r_held_err, n_held_err;

    logic [31:0]             grp;
    logic [31:0]             acc_abs;
    logic [2:0]              cnt_abs;
    logic [LEN_CNT_BITS-1:0] rem_dec;
    logic [32:0]             total;
    logic                    body_over;
    logic                    too_long;
    logic                    more;

    function automatic t_result err_res(input logic [1:0] code);
        t_result r;
        r.kind          = KIND_ERROR;
        r.payload_byte  = 8'd0;
        r.frame_tag     = 32'sd0;
        r.last_of_frame = 1'b0;
        r.error_code    = code;
        return r;
    endfunction

    function automatic t_result data_res(input logic [1:0] kind, input logic [7:0] b,
                                         input logic [31:0] id, input logic last);
        t_result r;
        r.kind          = kind;
        r.payload_byte  = b;
        r.frame_tag     = id;
        r.last_of_frame = last;
        r.error_code    = ERR_NEG;
        return r;
    endfunction

    // Seven-bit group placed at the position given by the byte count; bits of the
    // fifth byte beyond 32 are dropped.
    always_comb begin
        unique case (r_vcount)
            3'd0:    grp = {25'd0, i_data_byte[6:0]};
            3'd1:    grp = {18'd0, i_data_byte[6:0], 7'd0};
            3'd2:    grp = {11'd0, i_data_byte[6:0], 14'd0};
            3'd3:    grp = {4'd0, i_data_byte[6:0], 21'd0};
            3'd4:    grp = {i_data_byte[3:0], 28'd0};
            default: grp = 32'd0;
        endcase
    end

    assign acc_abs   = r_accum | grp;
    assign cnt_abs   = r_vcount + 3'd1;
    assign more      = i_data_byte[7];
    assign rem_dec   = r_rem - LEN_CNT_BITS'(1);
    assign total     = {1'b0, acc_abs} + {30'd0, cnt_abs};
    assign too_long  = total > {8'd0, r_max_len};
    assign body_over = (({1'b0, acc_abs[30:0]}) >> LEN_CNT_BITS) != 32'd0;

    always_comb begin
        n_max_len  = i_cfg_valid ? i_cfg_data : r_max_len;
        n_phase    = r_phase;
        n_accum    = r_accum;
        n_vcount   = r_vcount;
        n_rem      = r_rem;
        n_hdr_cnt  = r_hdr_cnt;
        n_cur_id   = r_cur_id;
        n_held_err = r_held_err;
        o_push     = '0;

        if (i_accept) begin
            if (i_op == OP_DISCARD) begin
                n_phase    = PH_LEN;
                n_accum    = '0;
                n_vcount   = '0;
                n_rem      = '0;
                n_hdr_cnt  = '0;
                n_cur_id   = '0;
                n_held_err = '0;
            end else begin
                unique case (r_phase)
                    PH_LEN: begin
                        n_accum   = acc_abs;
                        n_vcount  = cnt_abs;
                        n_hdr_cnt = cnt_abs;
                        priority if (more) begin
                            if (cnt_abs >= VARINT_MAX_BYTES) begin
                                n_phase    = PH_ERR;
                                n_held_err = ERR_OVERLONG;
                                o_push     = '{valid: 1'b1, res: err_res(ERR_OVERLONG)};
                            end
                        end else if (acc_abs[31]) begin
                            n_phase    = PH_ERR;
                            n_held_err = ERR_NEG;
                            o_push     = '{valid: 1'b1, res: err_res(ERR_NEG)};
                        end else if (too_long || body_over) begin
                            n_phase    = PH_ERR;
                            n_held_err = ERR_TOOLONG;
                            o_push     = '{valid: 1'b1, res: err_res(ERR_TOOLONG)};
                        end else if (acc_abs == 32'd0) begin
                            // No room in the body for the id.
                            n_phase    = PH_ERR;
                            n_held_err = ERR_BADID;
                            o_push     = '{valid: 1'b1, res: err_res(ERR_BADID)};
                        end else begin
                            n_rem    = acc_abs[LEN_CNT_BITS-1:0];
                            n_accum  = '0;
                            n_vcount = '0;
                            n_phase  = PH_ID;
                        end
                    end
                    PH_ID: begin
                        n_accum  = acc_abs;
                        n_vcount = cnt_abs;
                        n_rem    = rem_dec;
                        priority if (more) begin
                            if (cnt_abs >= VARINT_MAX_BYTES || rem_dec == '0) begin
                                n_phase    = PH_ERR;
                                n_held_err = ERR_BADID;
                                o_push     = '{valid: 1'b1, res: err_res(ERR_BADID)};
                            end
                        end else if (rem_dec == '0) begin
                            // Frame with an empty payload ends on its id.
                            o_push    = '{valid: 1'b1,
                                          res: data_res(KIND_EMPTY, 8'd0, acc_abs, 1'b1)};
                            n_phase   = PH_LEN;
                            n_accum   = '0;
                            n_vcount  = '0;
                            n_hdr_cnt = '0;
                            n_cur_id  = '0;
                        end else begin
                            n_cur_id = acc_abs;
                            n_accum  = '0;
                            n_vcount = '0;
                            n_phase  = PH_PAY;
                        end
                    end
                    PH_PAY: begin
                        n_rem  = rem_dec;
                        o_push = '{valid: 1'b1,
                                   res: data_res(KIND_PAYLOAD, i_data_byte, r_cur_id,
                                                 rem_dec == '0)};
                        if (rem_dec == '0) begin
                            n_phase   = PH_LEN;
                            n_hdr_cnt = '0;
                            n_cur_id  = '0;
                        end
                    end
                    PH_ERR: begin
                        o_push = '{valid: 1'b1, res: err_res(r_held_err)};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= MAX_FRAME_RESET;
            r_phase    <= PH_LEN;
            r_accum    <= '0;
            r_vcount   <= '0;
            r_rem      <= '0;
            r_hdr_cnt  <= '0;
            r_cur_id   <= '0;
            r_held_err <= '0;
        end else begin
            r_max_len  <= n_max_len;
            r_phase    <= n_phase;
            r_accum    <= n_accum;
            r_vcount   <= n_vcount;
            r_rem      <= n_rem;
            r_hdr_cnt  <= n_hdr_cnt;
            r_cur_id   <= n_cur_id;
            r_held_err <= n_held_err;
        end
    end

    `VLFD_ASSERT_NEXT(a_error_sticks, o_push.valid && o_push.res.kind == KIND_ERROR, r_phase == PH_ERR, "error result without error phase")
    `VLFD_ASSERT(a_varint_bounded, r_vcount <= VARINT_MAX_BYTES, "varint byte count beyond limit")
    `VLFD_ASSERT_NEXT(a_discard_clears, i_accept && i_op == OP_DISCARD, r_phase == PH_LEN && r_held_err == ERR_NEG, "discard left state behind")

endmodule

[design/vlfd_queue.sv]
// Back part of the deframer: short result queue feeding the output channel.
// Depends on vlfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vlfd_queue
    import vlfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_full,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_head
);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              pop;

    assign o_full      = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_out_valid = r_count != '0;
    assign o_head      = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        n_wr_ptr = i_push.valid ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push.valid) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `VLFD_ASSERT(a_no_overflow, !(i_push.valid && o_full), "push into a full queue")
    `VLFD_ASSERT(a_count_bounded, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `VLFD_ASSERT_NEXT(a_push_counts, i_push.valid && !pop, r_count == $past(r_count) + QCNT_W'(1), "push not counted")

endmodule

[design/varint_length_frame_deframer_unit.sv]
// Top level of the varint length frame deframer.
// Depends on vlfd_pkg, vlfd_front and vlfd_queue.
//
// Takes a received byte stream one beat per cycle and splits it into frames: a varint
// body length, a varint packet id inside the body, then payload bytes. Each payload
// byte leaves as one output beat tagged with its packet id, the final byte flagged
// last; a frame with an empty payload gives a single empty-frame beat. Length and id
// bytes give no output. A negative length, a length varint longer than five bytes, a
// frame longer than the maximum frame length register, or a malformed id enters a
// sticky error state in which every stream byte gives an error beat; a discard beat
// (op set) clears it and drops any partial frame. Throughput is one input beat per
// cycle: the front decoder does all its work for a beat in the cycle it is accepted
// and writes any result into a four-entry queue that drives the output channel.
// The input stalls only when that queue is full, that is after the output side has
// held off for four results. The maximum frame length register is written through
// its own channel, which is always ready, and should be written only while no frame
// is in flight.
module varint_length_frame_deframer_unit
    import vlfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic [7:0]         i_data_byte,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_payload_byte,
    output logic signed [31:0] o_frame_tag,
    output logic               o_last_of_frame,
    output logic [1:0]         o_error_code
);

    logic    accept;
    logic    full;
    t_push   push;
    t_result head;

    // The register write needs no wait state.
    assign o_cfg_ready = 1'b1;

    // Ready depends only on queue space, never on the decoder phase.
    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    vlfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_push      (push)
    );

    vlfd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_head      (head)
    );

    assign o_kind          = head.kind;
    assign o_payload_byte  = head.payload_byte;
    assign o_frame_tag     = head.frame_tag;
    assign o_last_of_frame = head.last_of_frame;
    assign o_error_code    = head.error_code;

endmodule

[sim/varint_length_frame_deframer_unit_test.sv]
// Self-checking testbench for varint_length_frame_deframer_unit.
// Needs vlfd_pkg and the deframer RTL only; it predicts every output beat
// itself and compares them in order as they leave the block.
`timescale 1ns / 100ps

module varint_length_frame_deframer_unit_test;
    import vlfd_pkg::*;

    // Generous bound on the run.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Largest body the length counter can hold.
    localparam logic [31:0] BODY_MAX = (32'd1 << LEN_CNT_BITS) - 32'd1;
    // Length of the one long receiver hold-off, and when it starts.
    localparam int HOLD_CYCLES = 60;
    localparam int HOLD_AFTER_BEATS = 80;

    typedef struct packed {
        logic       op;
        logic [7:0] octet;
    } stream_item_t;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_op = OP_BYTE;
    logic [7:0]         i_data_byte = 8'd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_kind;
    logic [7:0]         o_payload_byte;
    logic signed [31:0] o_frame_tag;
    logic               o_last_of_frame;
    logic [1:0]         o_error_code;

    varint_length_frame_deframer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_payload_byte  (o_payload_byte),
        .o_frame_tag     (o_frame_tag),
        .o_last_of_frame (o_last_of_frame),
        .o_error_code    (o_error_code)
    );

    // Stream beats waiting to be offered, and output beats predicted but not
    // yet seen, oldest first.
    stream_item_t rx_stream[$];
    t_result      due_beats[$];

    int          mismatches = 0;
    int          beats_seen = 0;
    int unsigned cycle_count = 0;
    // Set by the monitor when the beat on offer is taken, cleared by the driver.
    bit          in_taken = 1'b0;
    // In the closing phase neither side idles.
    bit          calm = 1'b0;

    // The testbench's own copy of the deframer state and of its register.
    logic [1:0]              dec_phase = PH_LEN;
    logic [31:0]             acc = '0;
    logic [2:0]              acc_n = '0;
    logic [LEN_CNT_BITS-1:0] body_left = '0;
    logic [2:0]              hdr_n = '0;
    logic [31:0]             frame_id = '0;
    logic [1:0]              sticky_code = '0;
    logic [CFG_W-1:0]        frame_limit = MAX_FRAME_RESET;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Drops any partial frame and goes back to waiting for a length varint.
    function automatic void restart_frame();
        dec_phase = PH_LEN;
        acc = '0;
        acc_n = '0;
        body_left = '0;
        hdr_n = '0;
        frame_id = '0;
    endfunction

    // Folds one varint byte into the accumulator, seven bits at a time, low
    // group first. Groups that would land above bit 31 are lost, as are the top
    // bits of a fifth group. Returns the continuation flag.
    function automatic bit take_group(input logic [7:0] b);
        logic [5:0] sh;
        sh = 6'(acc_n) * 6'd7;
        if (sh < 6'd32)
            acc = acc | (32'(b[6:0]) << sh);
        acc_n = acc_n + 3'd1;
        return b[7];
    endfunction

    // Enters the sticky error state and builds the error beat for the byte
    // that caused it.
    function automatic void enter_fault(input logic [1:0] code, output t_result r);
        dec_phase = PH_ERR;
        sticky_code = code;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
    endfunction

    // Advances the predicted state by one input beat. Returns 1 when the beat
    // produces an output beat, which is then left in r.
    function automatic bit deframe_step(input logic op, input logic [7:0] b,
                                        output t_result r);
        bit          more;
        logic [32:0] total;
        logic [31:0] id;
        r = '0;
        if (op == OP_DISCARD) begin
            sticky_code = '0;
            restart_frame();
            return 1'b0;
        end
        case (dec_phase)
            PH_LEN: begin
                more = take_group(b);
                hdr_n = acc_n;
                if (more) begin
                    if (acc_n >= VARINT_MAX_BYTES) begin
                        enter_fault(ERR_OVERLONG, r);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (acc[31]) begin
                    enter_fault(ERR_NEG, r);
                    return 1'b1;
                end
                // The limit counts the length bytes as well as the body.
                total = {1'b0, acc} + 33'(hdr_n);
                if (total > 33'(frame_limit) || acc > BODY_MAX) begin
                    enter_fault(ERR_TOOLONG, r);
                    return 1'b1;
                end
                // A zero body has no room for the packet id.
                if (acc == '0) begin
                    enter_fault(ERR_BADID, r);
                    return 1'b1;
                end
                body_left = acc[LEN_CNT_BITS-1:0];
                acc = '0;
                acc_n = '0;
                dec_phase = PH_ID;
                return 1'b0;
            end
            PH_ID: begin
                more = take_group(b);
                body_left = body_left - 1'b1;
                if (more) begin
                    // The id may neither run past the body nor past five bytes.
                    if (acc_n >= VARINT_MAX_BYTES || body_left == '0) begin
                        enter_fault(ERR_BADID, r);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                frame_id = acc;
                acc = '0;
                acc_n = '0;
                if (body_left == '0) begin
                    id = frame_id;
                    restart_frame();
                    r.kind = KIND_EMPTY;
                    r.frame_tag = id;
                    r.last_of_frame = 1'b1;
                    return 1'b1;
                end
                dec_phase = PH_PAY;
                return 1'b0;
            end
            PH_PAY: begin
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.frame_tag = frame_id;
                body_left = body_left - 1'b1;
                if (body_left == '0) begin
                    r.last_of_frame = 1'b1;
                    restart_frame();
                end
                return 1'b1;
            end
            default: begin
                r.kind = KIND_ERROR;
                r.error_code = sticky_code;
                return 1'b1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic op, input logic [7:0] octet);
        stream_item_t it;
        it.op = op;
        it.octet = octet;
        rx_stream.push_back(it);
    endtask

    // Fewest bytes that carry v as a varint.
    function automatic int varint_size(input logic [31:0] v);
        int n;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0)
            n++;
        return n;
    endfunction

    // Queues v as a varint of exactly n bytes; more than the fewest pads it with
    // continuation bytes. Junk is put in the top bits of a fifth byte, which the
    // block must throw away.
    task automatic queue_varint(input logic [31:0] v, input int n);
        logic [7:0] octet;
        for (int i = 0; i < n; i++) begin
            octet = 8'((v >> (7 * i)) & 32'h7F);
            if (i == 4)
                octet[6:4] = 3'($urandom);
            octet[7] = (i < n - 1);
            queue_byte(OP_BYTE, octet);
        end
    endtask

    // Fills the stream with about target beats. Most of it is well-formed frames
    // with random ids, payloads and padding; the rest is broken framing of every
    // kind, noise and discards in the middle of frames. Every fault is followed
    // by a discard so that the next frame starts clean.
    task automatic queue_traffic(input int target);
        int          base, pay_len, id_n, len_n, body, hdr_len;
        logic [31:0] id;
        base = rx_stream.size();
        while (rx_stream.size() - base < target) begin
            if ($urandom_range(0, 99) < 72) begin
                case ($urandom_range(0, 2))
                    0:       id = $urandom_range(0, 127);
                    1:       id = $urandom_range(0, 32'h3FFFF);
                    default: id = $urandom;
                endcase
                pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 48)
                                                      : $urandom_range(0, 6);
                id_n = varint_size(id);
                if ($urandom_range(0, 5) == 0)
                    id_n = $urandom_range(id_n, 5);
                body = id_n + pay_len;
                len_n = varint_size(body);
                if ($urandom_range(0, 5) == 0)
                    len_n = $urandom_range(len_n, 5);
                queue_varint(body, len_n);
                queue_varint(id, id_n);
                repeat (pay_len) queue_byte(OP_BYTE, 8'($urandom));
                // A frame over the limit leaves the block in its error state.
                if (len_n + body > frame_limit || $urandom_range(0, 19) == 0)
                    queue_byte(OP_DISCARD, 8'($urandom));
            end else begin
                case ($urandom_range(0, 5))
                    0: repeat ($urandom_range(1, 6)) queue_byte(OP_BYTE, 8'($urandom));
                    1: begin
                        // Packet id still going when the body runs out.
                        hdr_len = $urandom_range(1, 4);
                        queue_varint(hdr_len, 1);
                        repeat (hdr_len) queue_byte(OP_BYTE, 8'h80 | 8'($urandom_range(0, 127)));
                    end
                    2: begin
                        // Packet id of more than five bytes inside a roomy body.
                        queue_varint($urandom_range(6, 20), 1);
                        repeat (5) queue_byte(OP_BYTE, 8'h80 | 8'($urandom_range(0, 127)));
                    end
                    3: repeat (5) queue_byte(OP_BYTE, 8'h80 | 8'($urandom_range(0, 127)));
                    4: queue_varint({1'b1, 31'($urandom)}, 5);
                    default: begin
                        // Discard part way through a good frame.
                        queue_varint($urandom_range(4, 30), 1);
                        queue_varint($urandom_range(0, 127), 1);
                        repeat ($urandom_range(0, 2)) queue_byte(OP_BYTE, 8'($urandom));
                    end
                endcase
                // Bytes after a fault each give an error beat with the held code.
                repeat ($urandom_range(0, 3)) queue_byte(OP_BYTE, 8'($urandom));
                queue_byte(OP_DISCARD, 8'($urandom));
            end
        end
    endtask

    // Waits until every beat has been offered and taken and every predicted
    // output beat has arrived, then lets the clock run on so that the block is idle.
    task automatic wait_drained();
        while (rx_stream.size() != 0 || i_in_valid || due_beats.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes the maximum frame length register; only called while idle.
    task automatic set_frame_limit(input logic [CFG_W-1:0] limit);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers the next stream beat at the falling edge, holding it
    // steady until the block takes it, with random idle bursts in between.
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(negedge i_clk) begin : drive_stream
        stream_item_t nxt;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (rx_stream.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
                // Random idle gap before the next beat.
                send_gap = $urandom_range(0, 3);
                i_in_valid <= 1'b0;
            end else if (rx_stream.size() != 0) begin
                nxt = rx_stream.pop_front();
                i_in_valid <= 1'b1;
                i_op <= nxt.op;
                i_data_byte <= nxt.octet;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready: short random stalls, plus one long hold-off once enough
    // beats have gone by, long enough for the result queue to fill and the
    // input side to stall while the driver keeps offering.
    // ------------------------------------------------------------------
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_used = 1'b0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_used && beats_seen >= HOLD_AFTER_BEATS) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge it tracks register writes, predicts the
    // outcome of a taken input beat and checks a taken output beat against the
    // oldest prediction. The prediction is queued first, so a block that
    // answered in the same cycle would still be checked in order.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_beats
        t_result fresh;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                frame_limit = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                if (deframe_step(i_op, i_data_byte, fresh))
                    due_beats.push_back(fresh);
            end
            if (o_out_valid && i_out_ready) begin
                beats_seen++;
                if (due_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output beat: kind %0d byte %02h id %0d last %0b code %0d",
                                 o_kind, o_payload_byte, o_frame_tag, o_last_of_frame,
                                 o_error_code);
                end else begin
                    want = due_beats.pop_front();
                    if (o_kind !== want.kind || o_payload_byte !== want.payload_byte ||
                        o_frame_tag !== want.frame_tag ||
                        o_last_of_frame !== want.last_of_frame ||
                        o_error_code !== want.error_code) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("output beat %0d: expected kind %0d byte %02h id %0d last %0b code %0d, got kind %0d byte %02h id %0d last %0b code %0d",
                                     beats_seen, want.kind, want.payload_byte, want.frame_tag,
                                     want.last_of_frame, want.error_code, o_kind,
                                     o_payload_byte, o_frame_tag, o_last_of_frame,
                                     o_error_code);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset value of the frame limit.
        // Frame with an empty payload and id zero.
        queue_byte(OP_BYTE, 8'h07 - 8'h06);
        queue_byte(OP_BYTE, 8'h00);
        // Most negative id in five bytes, then the smallest and largest payload bytes.
        queue_byte(OP_BYTE, 8'h07);
        queue_varint(32'h8000_0000, 5);
        queue_byte(OP_BYTE, 8'h00);
        queue_byte(OP_BYTE, 8'hFF);
        // Length with its sign bit set, then a byte that sees the held error.
        queue_varint(32'h8000_0000, 5);
        queue_byte(OP_BYTE, 8'h55);
        queue_byte(OP_DISCARD, 8'hFF);
        // Zero body length: no room for an id.
        queue_byte(OP_BYTE, 8'h00);
        queue_byte(OP_DISCARD, 8'h00);
        // Length varint still continuing in its fifth byte.
        repeat (4) queue_byte(OP_BYTE, 8'hFF);
        queue_byte(OP_BYTE, 8'h8F);
        queue_byte(OP_DISCARD, 8'h00);
        // Two-byte body whose id never ends.
        queue_byte(OP_BYTE, 8'h02);
        queue_byte(OP_BYTE, 8'h80);
        queue_byte(OP_BYTE, 8'h80);
        queue_byte(OP_DISCARD, 8'h00);
        wait_drained();

        // Smallest limit: every frame is too long.
        set_frame_limit(CFG_W'(1));
        queue_traffic(40);
        wait_drained();

        // Reset value of the limit; the long receiver hold-off falls in this phase.
        set_frame_limit(MAX_FRAME_RESET);
        queue_traffic(150);
        wait_drained();

        // Small limits put the too-long check right at the size of real frames.
        set_frame_limit(CFG_W'($urandom_range(4, 40)));
        queue_traffic(150);
        wait_drained();

        // Closing phase with a random limit and neither side idling.
        set_frame_limit(CFG_W'($urandom_range(1, 16777216)));
        calm = 1'b1;
        queue_traffic(150);
        wait_drained();

        if (mismatches == 0 && due_beats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/vlfd_pkg.sv
design/vlfd_front.sv
design/vlfd_queue.sv
design/varint_length_frame_deframer_unit.sv
sim/varint_length_frame_deframer_unit_test.sv
